@@ rtl/letu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// letu_pkg
// Shared types, codes and helpers for the learned edge transition table unit.
// ----------------------------------------------------------------------------
package letu_pkg;

  localparam int PIN_W         = 16;
  localparam int PAGE_W        = 8;
  localparam int CMD_W         = 3;
  localparam int STATUS_W      = 3;
  localparam int COUNT_W       = 5;
  localparam int TABLE_DEPTH_D = 16;

  localparam logic [PAGE_W-1:0] PAGE_NONE   = PAGE_W'(0);
  localparam logic [PAGE_W-1:0] PAGE_GLOBAL = PAGE_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_READ   = 3'd0,
    CMD_LEARN  = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_COUNT  = 3'd4,
    CMD_SET    = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NOP       = 3'd0,
    ST_MATCH     = 3'd1,
    ST_ADDED     = 3'd2,
    ST_FULL      = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  // One stored rule. Edge and mask words: fall mask low, rise mask high.
  typedef struct packed {
    logic               global_rule;
    logic [PIN_W-1:0]   feedback;
    logic [2*PIN_W-1:0] in_edges;
    logic [2*PIN_W-1:0] out_masks;
  } rule_t;

  function automatic logic [2*PIN_W-1:0] pack_edges(input logic [PIN_W-1:0] before_v,
                                                    input logic [PIN_W-1:0] after_v);
    logic [PIN_W-1:0] fall;
    logic [PIN_W-1:0] rise;
    fall = before_v & ~after_v;
    rise = ~before_v & after_v;
    return {rise, fall};
  endfunction

endpackage

@@ rtl/letu_rule_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// letu_rule_mem
// Rule storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module letu_rule_mem import letu_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_D,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  rule_t         wr_rule,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output rule_t         rd_rule
);

  rule_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_rule;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_rule <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/letu_match.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// letu_match
// Shared rule comparator, one slot per cycle.
// ----------------------------------------------------------------------------
module letu_match import letu_pkg::*; (
  input  logic               slot_valid,
  input  rule_t              rule,
  input  logic [2*PIN_W-1:0] key_edges,
  input  logic [PIN_W-1:0]   cur_out,
  output logic               hit
);

  // global rules ignore the feedback, local ones need it equal to the output
  assign hit = slot_valid && (rule.in_edges == key_edges) &&
               (rule.global_rule || (rule.feedback == cur_out));

endmodule

@@ rtl/learned_edge_transition_table_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// learned_edge_transition_table_unit
// Learnable edge-driven transition table with a slot-serial rule scan.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item is taken on a rising edge with start high and
//   busy low; command, pin_value, next_output and rule_page are sampled then.
//   Result channel: done is high for exactly one cycle with output_value,
//   status and rule_count; the receiver must take it, it cannot stall.
// Timing:
//   Read, learn (page non-zero), remove and count scan the rule store one
//   slot per cycle through its single read port and one shared comparator,
//   then pass through S_FINISH, which raises done. Clear, set output, learn
//   with page 0 and unused codes skip the scan and go straight from accept
//   to S_FINISH. busy is high from accept until done rises, so a new item
//   may be taken at the edge that ends the done cycle.
// Reset:
//   rst (synchronous) empties every slot via the valid flags and zeroes the
//   previous input and the output; rule contents need no clearing.
// ----------------------------------------------------------------------------
module learned_edge_transition_table_unit import letu_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_D
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    command,
  input  logic [PIN_W-1:0]    pin_value,
  input  logic [PIN_W-1:0]    next_output,
  input  logic [PAGE_W-1:0]   rule_page,
  output logic                done,
  output logic [PIN_W-1:0]    output_value,
  output logic [STATUS_W-1:0] status,
  output logic [COUNT_W-1:0]  rule_count
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] SCAN_END = CW'(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state;

  logic [CMD_W-1:0]    cmd_q;
  logic [PIN_W-1:0]    pin_q;
  logic [PIN_W-1:0]    next_q;
  logic                global_q;
  logic                rule_page_nz_q;
  logic [2*PIN_W-1:0]  edges_q;
  logic [PIN_W-1:0]    previous_input;
  logic [PIN_W-1:0]    current_output;
  logic [TABLE_DEPTH-1:0] valid;

  logic [CW-1:0]       issue_cnt;
  logic                cmp_vld;
  logic [AW-1:0]       cmp_idx;

  logic                hit_found;
  logic [AW-1:0]       hit_idx;
  rule_t               hit_rule;
  logic                free_found;
  logic [AW-1:0]       free_idx;
  logic [CW-1:0]       count_q;

  status_t             status_q;
  logic [COUNT_W-1:0]  rule_count_q;

  logic                accept;
  logic                issuing;
  logic                needs_scan;
  logic                hit;
  rule_t               rd_rule;
  logic                wr_en;
  rule_t               wr_rule;
  logic [PIN_W-1:0]    fire_out;

  assign accept  = start && (state == S_IDLE);
  assign busy    = (state != S_IDLE);
  assign issuing = (state == S_SCAN) && (issue_cnt != SCAN_END);

  always_comb begin
    unique case (command)
      CMD_READ, CMD_REMOVE, CMD_COUNT: needs_scan = 1'b1;
      CMD_LEARN:                       needs_scan = (rule_page != PAGE_NONE);
      default:                         needs_scan = 1'b0;
    endcase
  end

  letu_rule_mem #(.TABLE_DEPTH(TABLE_DEPTH)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (free_idx),
    .wr_rule (wr_rule),
    .rd_en   (issuing),
    .rd_addr (issue_cnt[AW-1:0]),
    .rd_rule (rd_rule)
  );

  letu_match u_match (
    .slot_valid (valid[cmp_idx]),
    .rule       (rd_rule),
    .key_edges  (edges_q),
    .cur_out    (current_output),
    .hit        (hit)
  );

  // learn writes only when the scan found no duplicate and a free slot
  assign wr_en = (state == S_FINISH) && (cmd_q == CMD_LEARN) && (rule_page_nz_q) &&
                 !hit_found && free_found;

  always_comb begin
    wr_rule.global_rule = global_q;
    wr_rule.feedback    = current_output;
    wr_rule.in_edges    = edges_q;
    wr_rule.out_masks   = pack_edges(current_output, next_q);
  end

  assign fire_out = (hit_rule.feedback | hit_rule.out_masks[2*PIN_W-1:PIN_W]) &
                    ~hit_rule.out_masks[PIN_W-1:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q          <= command;
      pin_q          <= pin_value;
      next_q         <= next_output;
      global_q       <= (rule_page == PAGE_GLOBAL);
      rule_page_nz_q <= (rule_page != PAGE_NONE);
      edges_q        <= pack_edges(previous_input, pin_value);
    end
    if (cmp_vld && hit && !hit_found) begin
      hit_idx  <= cmp_idx;
      hit_rule <= rd_rule;
    end
    if (cmp_vld && !valid[cmp_idx] && !free_found) begin
      free_idx <= cmp_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      previous_input <= '0;
      current_output <= '0;
      valid          <= '0;
      issue_cnt      <= '0;
      cmp_vld        <= 1'b0;
      cmp_idx        <= '0;
      hit_found      <= 1'b0;
      free_found     <= 1'b0;
      count_q        <= '0;
      done           <= 1'b0;
      status_q       <= ST_NOP;
      rule_count_q   <= '0;
    end else begin
      done    <= 1'b0;
      cmp_vld <= issuing;
      cmp_idx <= issue_cnt[AW-1:0];
      if (issuing) begin
        issue_cnt <= issue_cnt + CW'(1);
      end
      if (cmp_vld) begin
        if (hit) begin
          hit_found <= 1'b1;
        end
        if (!valid[cmp_idx]) begin
          free_found <= 1'b1;
        end
        count_q <= count_q + CW'(valid[cmp_idx]);
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            issue_cnt  <= '0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            count_q    <= '0;
            state      <= needs_scan ? S_SCAN : S_FINISH;
          end
        end
        S_SCAN: begin
          if (cmp_vld && (cmp_idx == LAST_IDX)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          state        <= S_IDLE;
          done         <= 1'b1;
          status_q     <= ST_NOP;
          rule_count_q <= '0;
          unique case (cmd_q)
            CMD_READ: begin
              previous_input <= pin_q;
              if (hit_found) begin
                current_output <= fire_out;
                status_q       <= ST_MATCH;
              end
            end
            CMD_LEARN: begin
              if (rule_page_nz_q) begin
                if (hit_found) begin
                  status_q <= ST_MATCH;
                end else if (free_found) begin
                  valid[free_idx] <= 1'b1;
                  status_q        <= ST_ADDED;
                end else begin
                  status_q <= ST_FULL;
                end
              end
            end
            CMD_REMOVE: begin
              if (hit_found) begin
                valid[hit_idx] <= 1'b0;
                status_q       <= ST_REMOVED;
              end else begin
                status_q <= ST_NOT_FOUND;
              end
            end
            CMD_CLEAR: begin
              valid          <= '0;
              current_output <= '0;
            end
            CMD_COUNT: begin
              rule_count_q <= COUNT_W'(count_q);
            end
            CMD_SET: begin
              current_output <= next_q;
            end
            default: begin
            end
          endcase
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign output_value = current_output;
  assign status       = status_q;
  assign rule_count   = rule_count_q;

endmodule
